// ===== rtl/wpb_pkg.sv =====
package wpb_pkg;

  // internal count width: holds places + 1 for the largest 9-bit total
  localparam int CNT_W      = 10;
  localparam int STEP_W     = $clog2(CNT_W + 1);
  localparam int RES_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int MODE_W     = 3;

  localparam int DEFAULT_MAX_PLACES  = 256;
  localparam int DEFAULT_MAX_WORKERS = 256;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_MASTER = 3'd0,
    MODE_CLOSE  = 3'd1,
    MODE_SPREAD = 3'd2,
    MODE_FALSE  = 3'd3,
    MODE_TRUE   = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIND_MODE    = 2'd0,
    REG_PLACE_TOTAL  = 2'd1,
    REG_WORKER_TOTAL = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic start;
    cnt_t dividend;
    cnt_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    cnt_t quot;
    cnt_t rem;
  } div_rsp_t;

endpackage

// ===== rtl/worker_place_binding.sv =====
// Worker place binding: each input beat asks for the placement of the next
// worker of the current pass, and each output beat returns the worker index,
// its place, an unbound flag and a last-worker flag. The policy and the two
// totals come from a plain write port (index 0 bind mode, 1 place total,
// 2 worker total); a write to any of these makes the next beat start a new
// pass, as does restart_i or wrapping past the last worker. A beat that
// continues a pass is worked out in the cycle it is taken and its result is
// registered, so it appears in the next cycle. A beat that starts a pass
// first runs three divisions (workers/places, places/leftover,
// (places+1)/workers) one after the other on one shared restoring divider
// and then an emit step, and its result is registered after that (one
// division fewer when workers divide evenly over places). The input is not
// ready while the divider runs; a waiting result does not block the next
// beat as long as it is taken in the same cycle.
module worker_place_binding #(
  parameter int MAX_PLACES  = wpb_pkg::DEFAULT_MAX_PLACES,
  parameter int MAX_WORKERS = wpb_pkg::DEFAULT_MAX_WORKERS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [wpb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wpb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           restart_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wpb_pkg::RES_W-1:0]      worker_index_o,
  output logic [wpb_pkg::RES_W-1:0]      place_index_o,
  output logic                           unbound_o,
  output logic                           last_worker_o
);
  import wpb_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV_W = 5'b00010,
    ST_DIV_G = 5'b00100,
    ST_DIV_S = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e st_q, st_d;

  // configuration registers
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [CFG_DATA_W-1:0] ptot_q, ptot_d;
  logic [CFG_DATA_W-1:0] wtot_q, wtot_d;

  // pass state
  cnt_t cnt_q, cnt_d;       // next worker, 0 starts a pass
  cnt_t cur_q, cur_d;       // current place of the walk
  cnt_t wop_q, wop_d;       // workers already on the current place
  cnt_t gc_q, gc_d;         // places since the last extra
  cnt_t extra_q, extra_d;   // leftover workers not yet placed
  cnt_t ppq_q, ppq_d;       // workers per place
  cnt_t gl_q, gl_d;         // gap between places with an extra
  cnt_t sq_q, sq_d;         // spread step, whole part
  cnt_t sstep_q, sstep_d;   // spread step, fraction numerator
  cnt_t sr_q, sr_d;         // spread running fraction

  // output register
  logic             out_valid_q, out_valid_d;
  logic [RES_W-1:0] widx_q, widx_d;
  logic [RES_W-1:0] pidx_q, pidx_d;
  logic             unb_q, unb_d;
  logic             last_q, last_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  wpb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // effective totals and mode
  cnt_t  p_eff, w_eff, p_plus1;
  mode_e mode_eff;

  always_comb begin
    if (ptot_q == '0) begin
      p_eff = cnt_t'(1);
    end else if (int'(ptot_q) > MAX_PLACES) begin
      p_eff = cnt_t'(MAX_PLACES);
    end else begin
      p_eff = cnt_t'(ptot_q);
    end
    if (wtot_q == '0) begin
      w_eff = cnt_t'(1);
    end else if (int'(wtot_q) > MAX_WORKERS) begin
      w_eff = cnt_t'(MAX_WORKERS);
    end else begin
      w_eff = cnt_t'(wtot_q);
    end
    p_plus1  = p_eff + cnt_t'(1);
    mode_eff = (mode_q > MODE_TRUE) ? MODE_TRUE : mode_e'(mode_q);
  end

  logic in_acc;
  logic start_c;

  assign in_ready_o = (st_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign start_c    = restart_i || (cnt_q == '0) || (cnt_q >= w_eff);

  // one placement step on the current pass state
  cnt_t           s_cur, s_wop, s_gc, s_extra, s_sr, s_place, s_cnt, idx_inc;
  logic           s_unb, s_last;
  logic [CNT_W:0] sum_sr;
  logic           sum_ge;
  logic           gap_hit;
  cnt_t           wop_inc;
  logic           p_ge_w;

  always_comb begin
    s_cur   = cur_q;
    s_wop   = wop_q;
    s_gc    = gc_q;
    s_extra = extra_q;
    s_sr    = sr_q;
    s_place = '0;
    s_unb   = 1'b0;
    p_ge_w  = p_eff >= w_eff;
    sum_sr  = {1'b0, sr_q} + {1'b0, sstep_q};
    sum_ge  = sum_sr >= {1'b0, w_eff};
    gap_hit = (extra_q != '0) && (gc_q == gl_q);
    wop_inc = wop_q + cnt_t'(1);
    unique case (mode_eff)
      MODE_FALSE: begin
        s_unb = 1'b1;
      end
      MODE_MASTER: begin
        s_place = '0;
      end
      default: begin
        if (mode_eff == MODE_CLOSE && p_ge_w) begin
          s_place = cnt_q;
        end else if (p_ge_w) begin
          // exact floor(i * (places + 1) / workers) walk
          s_place = cur_q;
          s_cur   = cur_q + sq_q + cnt_t'(sum_ge);
          s_sr    = sum_ge ? cnt_t'(sum_sr - {1'b0, w_eff}) : sum_sr[CNT_W-1:0];
        end else begin
          // fewer places than workers: quotient plus spaced extras
          s_place = cur_q;
          s_wop   = wop_inc;
          if (wop_inc == ppq_q && gap_hit) begin
            s_wop = wop_inc;
          end else if (wop_inc == ppq_q + cnt_t'(1) && gap_hit) begin
            s_cur   = cur_q + cnt_t'(1);
            s_wop   = '0;
            s_gc    = cnt_t'(1);
            s_extra = extra_q - cnt_t'(1);
          end else if (wop_inc == ppq_q) begin
            s_cur = cur_q + cnt_t'(1);
            s_gc  = gc_q + cnt_t'(1);
            s_wop = '0;
          end
        end
      end
    endcase
    idx_inc = cnt_q + cnt_t'(1);
    s_last  = idx_inc == w_eff;
    s_cnt   = s_last ? '0 : idx_inc;
  end

  // sequencer, pass state and output register
  logic do_step;

  always_comb begin
    st_d        = st_q;
    mode_d      = mode_q;
    ptot_d      = ptot_q;
    wtot_d      = wtot_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    wop_d       = wop_q;
    gc_d        = gc_q;
    extra_d     = extra_q;
    ppq_d       = ppq_q;
    gl_d        = gl_q;
    sq_d        = sq_q;
    sstep_d     = sstep_q;
    sr_d        = sr_q;
    widx_d      = widx_q;
    pidx_d      = pidx_q;
    unb_d       = unb_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_req     = '0;
    do_step     = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (start_c) begin
            cnt_d            = '0;
            cur_d            = '0;
            wop_d            = '0;
            sr_d             = '0;
            div_req.start    = 1'b1;
            div_req.dividend = w_eff;
            div_req.divisor  = p_eff;
            st_d             = ST_DIV_W;
          end else begin
            do_step = 1'b1;
          end
        end
      end
      ST_DIV_W: begin
        if (div_rsp.done) begin
          ppq_d         = div_rsp.quot;
          extra_d       = div_rsp.rem;
          div_req.start = 1'b1;
          if (div_rsp.rem != '0) begin
            div_req.dividend = p_eff;
            div_req.divisor  = div_rsp.rem;
            st_d             = ST_DIV_G;
          end else begin
            gl_d             = '0;
            gc_d             = '0;
            div_req.dividend = p_plus1;
            div_req.divisor  = w_eff;
            st_d             = ST_DIV_S;
          end
        end
      end
      ST_DIV_G: begin
        if (div_rsp.done) begin
          gl_d             = div_rsp.quot;
          gc_d             = div_rsp.quot;
          div_req.start    = 1'b1;
          div_req.dividend = p_plus1;
          div_req.divisor  = w_eff;
          st_d             = ST_DIV_S;
        end
      end
      ST_DIV_S: begin
        if (div_rsp.done) begin
          sq_d    = div_rsp.quot;
          sstep_d = div_rsp.rem;
          st_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        do_step = 1'b1;
        st_d    = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (do_step) begin
      cur_d       = s_cur;
      wop_d       = s_wop;
      gc_d        = s_gc;
      extra_d     = s_extra;
      sr_d        = s_sr;
      cnt_d       = s_cnt;
      widx_d      = cnt_q[RES_W-1:0];
      pidx_d      = s_place[RES_W-1:0];
      unb_d       = s_unb;
      last_d      = s_last;
      out_valid_d = 1'b1;
    end

    // any register write restarts the pass
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BIND_MODE: begin
          mode_d = cfg_data_i[MODE_W-1:0];
          cnt_d  = '0;
        end
        REG_PLACE_TOTAL: begin
          ptot_d = cfg_data_i;
          cnt_d  = '0;
        end
        REG_WORKER_TOTAL: begin
          wtot_d = cfg_data_i;
          cnt_d  = '0;
        end
        default: begin
          cnt_d = cnt_d;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mode_q      <= MODE_TRUE;
      ptot_q      <= CFG_DATA_W'(1);
      wtot_q      <= CFG_DATA_W'(1);
      cnt_q       <= '0;
      cur_q       <= '0;
      wop_q       <= '0;
      gc_q        <= '0;
      extra_q     <= '0;
      ppq_q       <= '0;
      gl_q        <= '0;
      sq_q        <= '0;
      sstep_q     <= '0;
      sr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      mode_q      <= mode_d;
      ptot_q      <= ptot_d;
      wtot_q      <= wtot_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      wop_q       <= wop_d;
      gc_q        <= gc_d;
      extra_q     <= extra_d;
      ppq_q       <= ppq_d;
      gl_q        <= gl_d;
      sq_q        <= sq_d;
      sstep_q     <= sstep_d;
      sr_q        <= sr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    widx_q <= widx_d;
    pidx_q <= pidx_d;
    unb_q  <= unb_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign worker_index_o = widx_q;
  assign place_index_o  = pidx_q;
  assign unbound_o      = unb_q;
  assign last_worker_o  = last_q;

  // divider only reports back while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (st_q == ST_DIV_W || st_q == ST_DIV_G || st_q == ST_DIV_S))
    else $error("divider done outside a division state");

  // a beat that starts a pass has no result in the next cycle
  a_start_no_early_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && start_c) |=> !out_valid_o)
    else $error("pass start produced a result without dividing");

  // unbound workers always report place 0
  a_unbound_place_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unbound_o) |-> (place_index_o == '0))
    else $error("unbound worker with nonzero place");

endmodule

// ===== rtl/wpb_div.sv =====
module wpb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wpb_pkg::div_req_t req_i,
  output wpb_pkg::div_rsp_t rsp_o
);
  import wpb_pkg::*;

  // restoring divider, one quotient bit per cycle
  cnt_t              rem_q, rem_d;
  cnt_t              quo_q, quo_d;
  cnt_t              dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;

  always_comb begin
    shifted = {rem_q, quo_q[CNT_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      step_d = STEP_W'(CNT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[CNT_W-1:0];
        quo_d = {quo_q[CNT_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[CNT_W-1:0];
        quo_d = {quo_q[CNT_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== tb/worker_place_binding_checker.sv =====
module worker_place_binding_checker #(
  parameter int MAX_PLACES  = wpb_pkg::DEFAULT_MAX_PLACES,
  parameter int MAX_WORKERS = wpb_pkg::DEFAULT_MAX_WORKERS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wpb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wpb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           restart_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [wpb_pkg::RES_W-1:0]      worker_index_i,
  input  logic [wpb_pkg::RES_W-1:0]      place_index_i,
  input  logic                           unbound_i,
  input  logic                           last_worker_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wpb_pkg::*;

  typedef struct packed {
    logic [RES_W-1:0] worker;
    logic [RES_W-1:0] place;
    logic             unbound;
    logic             last;
  } placement_t;

  // register copies
  logic [MODE_W-1:0]     mode_reg;
  logic [CFG_DATA_W-1:0] places_reg;
  logic [CFG_DATA_W-1:0] workers_reg;

  // pass state
  int unsigned next_worker;
  int unsigned walk_place;
  int unsigned on_place;
  int unsigned gap_run;
  int unsigned extra;
  int unsigned share;
  int unsigned gap;
  int unsigned stride;
  int unsigned frac;

  placement_t placements_q[$];
  placement_t want;
  placement_t got;
  int         fails;

  function automatic int unsigned bounded(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic placement_t next_placement(logic rs);
    int unsigned p;
    int unsigned w;
    int unsigned idx;
    int unsigned place;
    mode_e       md;
    bit          hit;
    placement_t  res;
    p     = bounded(places_reg, MAX_PLACES);
    w     = bounded(workers_reg, MAX_WORKERS);
    md    = (mode_reg > MODE_TRUE) ? MODE_TRUE : mode_e'(mode_reg);
    place = 0;
    res   = '0;
    // new pass: split workers over places and set up both walks
    if (rs || next_worker == 0 || next_worker >= w) begin
      next_worker = 0;
      walk_place  = 0;
      on_place    = 0;
      share       = w / p;
      extra       = w - share * p;
      gap         = (extra != 0) ? p / extra : 0;
      gap_run     = gap;
      stride      = (p + 1) / w;
      frac        = 0;
    end
    idx = next_worker;
    if (md == MODE_FALSE) begin
      res.unbound = 1'b1;
    end else if (md == MODE_MASTER) begin
      place = 0;
    end else if (md == MODE_CLOSE && p >= w) begin
      place = idx;
    end else if (p >= w) begin
      // exact floor(i*(p+1)/w) by quotient and running remainder
      place      = walk_place;
      walk_place += stride;
      frac       += (p + 1) - stride * w;
      if (frac >= w) begin
        frac -= w;
        walk_place++;
      end
    end else begin
      // too few places: share per place, one extra every gap-th place
      place = walk_place;
      hit   = (extra != 0) && (gap_run == gap);
      on_place++;
      if (hit && on_place == share + 1) begin
        walk_place++;
        on_place = 0;
        gap_run  = 1;
        extra--;
      end else if (!hit && on_place == share) begin
        walk_place++;
        gap_run++;
        on_place = 0;
      end
    end
    res.last    = (idx + 1 == w);
    next_worker = res.last ? 0 : idx + 1;
    res.worker  = idx[RES_W-1:0];
    res.place   = place[RES_W-1:0];
    return res;
  endfunction

  function automatic void compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_reg    = MODE_TRUE;
      places_reg  = 1;
      workers_reg = 1;
      next_worker = 0;
      walk_place  = 0;
      on_place    = 0;
      gap_run     = 0;
      extra       = 0;
      share       = 0;
      gap         = 0;
      stride      = 0;
      frac        = 0;
      fails       = 0;
      placements_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        // any known register write forces a fresh pass, the spare index does nothing
        case (cfg_index_i)
          REG_BIND_MODE: begin
            mode_reg    = cfg_data_i[MODE_W-1:0];
            next_worker = 0;
          end
          REG_PLACE_TOTAL: begin
            places_reg  = cfg_data_i;
            next_worker = 0;
          end
          REG_WORKER_TOTAL: begin
            workers_reg = cfg_data_i;
            next_worker = 0;
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) placements_q.push_back(next_placement(restart_i));
      if (out_valid_i && out_ready_i) begin
        got = '{worker_index_i, place_index_i, unbound_i, last_worker_i};
        if (placements_q.size() == 0) begin
          $error("result beat with no placement pending");
          fails++;
        end else begin
          want = placements_q.pop_front();
          compare_field("worker_index", want.worker, got.worker);
          compare_field("place_index", want.place, got.place);
          compare_field("unbound", want.unbound, got.unbound);
          compare_field("last_worker", want.last, got.last);
        end
      end
      pending_o    <= placements_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== tb/worker_place_binding_tb.sv =====
module worker_place_binding_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wpb_pkg::*;

  localparam int BEAT_TARGET    = 1550;
  // no beat on any channel for this long means the block is stuck
  localparam int WATCHDOG_LIMIT = 2000;
  // a pass start runs the divisions first, so give the tail some room past that
  localparam int TAIL_CYCLES    = 60;
  localparam int PHASE_CAP      = 300;
  // index 3 is not a register: writes there must leave the pass alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  restart     = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [RES_W-1:0]      worker_index;
  logic [RES_W-1:0]      place_index;
  logic                  unbound;
  logic                  last_worker;

  int fail_count;
  int pending;
  int beats_sent   = 0;
  int idle_cycles  = 0;
  int ready_left   = 0;
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  worker_place_binding dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .restart_i      (restart),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .worker_index_o (worker_index),
    .place_index_o  (place_index),
    .unbound_o      (unbound),
    .last_worker_o  (last_worker)
  );

  worker_place_binding_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .restart_i      (restart),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .worker_index_i (worker_index),
    .place_index_i  (place_index),
    .unbound_i      (unbound),
    .last_worker_i  (last_worker),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // result side back-pressure: bursts of ready, mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (!rx_stalls_on) begin
      out_ready  <= 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready  <= 1'b1;
      ready_left = $urandom_range(0, 29);
    end else begin
      out_ready  <= 1'b0;
      ready_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 39);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("worker_place_binding_tb: FAIL");
      $finish;
    end
  end

  // sender gap length: mostly back to back, sometimes a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // totals: mostly small, some medium, a few at or past the edges
  function automatic logic [CFG_DATA_W-1:0] pick_total();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return CFG_DATA_W'($urandom_range(1, 12));
    if (r < 85) return CFG_DATA_W'($urandom_range(13, 64));
    case ($urandom_range(0, 4))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(255);
      2:       return CFG_DATA_W'(256);
      3:       return CFG_DATA_W'($urandom_range(257, 511));
      default: return CFG_DATA_W'($urandom_range(65, 254));
    endcase
  endfunction

  // one request beat, with an optional gap in front
  task automatic send_beat(input logic rs);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // hold off requests until every placement has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // write all three registers back to back, block must be idle
  task automatic write_regs(input logic [CFG_DATA_W-1:0] mode_val,
                            input logic [CFG_DATA_W-1:0] places_val,
                            input logic [CFG_DATA_W-1:0] workers_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BIND_MODE;
    cfg_data  <= mode_val;
    @(posedge clk);
    cfg_index <= REG_PLACE_TOTAL;
    cfg_data  <= places_val;
    @(posedge clk);
    cfg_index <= REG_WORKER_TOTAL;
    cfg_data  <= workers_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic poke_spare();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned w_eff;
    int unsigned n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: mode true, one place, one worker
    send_beat(1'b0);

    // master with a zero place total, which counts as one place
    settle();
    write_regs(9'(MODE_MASTER), 9'd0, 9'd3);
    repeat (3) send_beat(1'b0);

    // false: every worker unbound
    settle();
    write_regs(9'(MODE_FALSE), 9'd5, 9'd2);
    repeat (2) send_beat(1'b0);

    // close with an oversized place total, restart in mid-pass
    settle();
    write_regs(9'(MODE_CLOSE), 9'd511, 9'd4);
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b0);

    // spread with spare places
    settle();
    write_regs(9'(MODE_SPREAD), 9'd7, 9'd3);
    repeat (3) send_beat(1'b0);

    // undefined mode code with junk in the upper data bits, too few places
    settle();
    write_regs(9'h1F7, 9'd3, 9'd5);
    repeat (5) send_beat(1'b0);

    // largest totals, a spare-index write in mid-pass must not restart it
    settle();
    write_regs(9'(MODE_TRUE), 9'd256, 9'd256);
    repeat (2) send_beat(1'b0);
    settle();
    poke_spare();
    repeat (2) send_beat(1'b0);

    // random phases: mostly whole passes, some restarts and drains
    while (beats_sent < BEAT_TARGET) begin
      settle();
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      write_regs(CFG_DATA_W'($urandom), pick_total(), pick_total());
      w_eff = (cfg_data == 0) ? 1 :
              (cfg_data > DEFAULT_MAX_WORKERS) ? DEFAULT_MAX_WORKERS : cfg_data;
      n = w_eff * $urandom_range(1, 3) + $urandom_range(0, 2);
      if (n > PHASE_CAP) n = PHASE_CAP;
      repeat (n) begin
        if ($urandom_range(0, 99) < 3) begin
          settle();
          if ($urandom_range(0, 1) != 0) poke_spare();
        end
        send_beat($urandom_range(0, 99) < 5);
      end
    end

    settle();
    rx_stalls_on = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("worker_place_binding_tb: PASS");
    end else begin
      $display("worker_place_binding_tb: FAIL");
    end
    $finish;
  end

endmodule
